@@ hw/rtl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg: shared constants of the postfix stack evaluator
// Stack sizing, data width, status codes and operator codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  // stack sizing
  localparam int unsigned StackDepth = 64;
  localparam int unsigned DepthW     = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned DataW      = 32;

  // result status codes
  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatUnderflow = 3'd1;
  localparam logic [2:0] StatOverflow  = 3'd2;
  localparam logic [2:0] StatBadDepth  = 3'd3;
  localparam logic [2:0] StatDivZero   = 3'd4;

  // operator codes
  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpMod = 3'd4;
  localparam logic [2:0] OpAnd = 3'd5;
  localparam logic [2:0] OpOr  = 3'd6;
  localparam logic [2:0] OpXor = 3'd7;

  // token kinds
  localparam logic ReqPush = 1'b0;
  localparam logic ReqOper = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rpn_stack_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core: postfix integer expression evaluator
// Token-driven value stack with a shared ALU and a bit-serial divider.
// ----------------------------------------------------------------------------
// Takes one token per input beat and is not ready again until that token is
// done. A push passes through dispatch and finish; add, sub, and, or, xor and
// mul add an execute step that uses the registered read of the second operand
// from the stack RAM, and div or mod go on from there to the shared restoring
// divider, which retires one quotient bit per cycle, and then to a sign step.
// The top of stack lives in a register and the rest in the stack RAM. A last
// token loads the output register, and waits in its finish state while an
// earlier result beat is still unclaimed; new tokens are accepted while a
// result beat waits. The first error sticks until the last token, which
// reports it with answer 0 and then empties the stack. No clearing pass is
// needed after reset.
`default_nettype none

module rpn_stack_evaluator_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // token channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic signed [31:0] operand_value_i,
  input  wire logic        [2:0]  op_code_i,
  input  wire logic               last_token_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      answer_o,
  output logic        [2:0]       status_o
);

  localparam int unsigned DW = rpn_pkg::DataW;
  localparam int unsigned NW = rpn_pkg::DepthW;
  localparam int unsigned AW = rpn_pkg::AddrW;

  typedef enum logic [2:0] {
    SIdle,
    SDispatch,
    SExec,
    SDiv,
    SSign,
    SFin
  } state_e;

  state_e          state_q;
  logic [NW-1:0]   depth_q;
  logic [2:0]      err_q;
  logic [DW-1:0]   tos_q;

  // latched token
  logic            req_q;
  logic [DW-1:0]   val_q;
  logic [2:0]      op_q;
  logic            last_q;

  // divider state
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   quo_q;
  logic [DW-1:0]   dvs_q;
  logic [4:0]      cnt_q;
  logic            neg_q;

  // output register
  logic            out_valid_q;
  logic [DW-1:0]   answer_q;
  logic [2:0]      status_q;

  // stack ram ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  logic [DW-1:0]   alu_res;
  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_diff;
  logic            rem_ge;
  logic            out_free;
  logic            fin_load;
  logic [2:0]      fin_status;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign answer_o    = $signed(answer_q);
  assign status_o    = status_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fin_load    = (state_q == SFin) && last_q && out_free;

  // stack ram: entries below the top of stack
  assign ram_we    = (state_q == SDispatch) && (err_q == rpn_pkg::StatOk) &&
                     (req_q == rpn_pkg::ReqPush) &&
                     (depth_q != NW'(rpn_pkg::StackDepth)) && (depth_q != '0);
  assign ram_waddr = AW'(depth_q - NW'(1));
  assign ram_raddr = AW'(depth_q - NW'(2));

  rpn_ram #(
    .Width (DW),
    .Depth (rpn_pkg::StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tos_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared alu: a from ram, b from top of stack
  always_comb begin
    case (op_q)
      rpn_pkg::OpAdd: alu_res = ram_rdata + tos_q;
      rpn_pkg::OpSub: alu_res = ram_rdata - tos_q;
      rpn_pkg::OpMul: alu_res = ram_rdata * tos_q;
      rpn_pkg::OpAnd: alu_res = ram_rdata & tos_q;
      rpn_pkg::OpOr:  alu_res = ram_rdata | tos_q;
      rpn_pkg::OpXor: alu_res = ram_rdata ^ tos_q;
      default:        alu_res = ram_rdata ^ tos_q;
    endcase
  end

  // operand magnitudes for the divider
  assign mag_a = ram_rdata[DW-1] ? (DW'(0) - ram_rdata) : ram_rdata;
  assign mag_b = tos_q[DW-1] ? (DW'(0) - tos_q) : tos_q;

  // one restoring divide step
  assign rem_sh   = {rem_q, quo_q[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign rem_ge   = !rem_diff[DW];

  // final status of an expression
  always_comb begin
    if (err_q != rpn_pkg::StatOk) begin
      fin_status = err_q;
    end else if (depth_q != NW'(1)) begin
      fin_status = rpn_pkg::StatBadDepth;
    end else begin
      fin_status = rpn_pkg::StatOk;
    end
  end

  // sequencer, stack control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      depth_q     <= '0;
      err_q       <= rpn_pkg::StatOk;
      out_valid_q <= 1'b0;
    end else begin
      // result beat held until claimed
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            req_q   <= req_type_i;
            val_q   <= operand_value_i;
            op_q    <= op_code_i;
            last_q  <= last_token_i;
            state_q <= SDispatch;
          end
        end
        SDispatch: begin
          state_q <= SFin;
          if (err_q == rpn_pkg::StatOk) begin
            if (req_q == rpn_pkg::ReqPush) begin
              if (depth_q == NW'(rpn_pkg::StackDepth)) begin
                err_q <= rpn_pkg::StatOverflow;
              end else begin
                tos_q   <= val_q;
                depth_q <= depth_q + NW'(1);
              end
            end else if (depth_q < NW'(2)) begin
              err_q <= rpn_pkg::StatUnderflow;
            end else begin
              state_q <= SExec;
            end
          end
        end
        SExec: begin
          state_q <= SFin;
          if (op_q == rpn_pkg::OpDiv || op_q == rpn_pkg::OpMod) begin
            if (tos_q == '0) begin
              err_q <= rpn_pkg::StatDivZero;
            end else begin
              rem_q   <= '0;
              quo_q   <= mag_a;
              dvs_q   <= mag_b;
              cnt_q   <= '0;
              neg_q   <= (op_q == rpn_pkg::OpDiv) ? (ram_rdata[DW-1] ^ tos_q[DW-1])
                                                  : ram_rdata[DW-1];
              state_q <= SDiv;
            end
          end else begin
            tos_q   <= alu_res;
            depth_q <= depth_q - NW'(1);
          end
        end
        SDiv: begin
          rem_q <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
          quo_q <= {quo_q[DW-2:0], rem_ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= SSign;
          end
        end
        SSign: begin
          if (op_q == rpn_pkg::OpDiv) begin
            tos_q <= neg_q ? (DW'(0) - quo_q) : quo_q;
          end else begin
            tos_q <= neg_q ? (DW'(0) - rem_q) : rem_q;
          end
          depth_q <= depth_q - NW'(1);
          state_q <= SFin;
        end
        SFin: begin
          if (!last_q) begin
            state_q <= SIdle;
          end else if (out_free) begin
            status_q    <= fin_status;
            answer_q    <= (fin_status == rpn_pkg::StatOk) ? tos_q : '0;
            depth_q     <= '0;
            err_q       <= rpn_pkg::StatOk;
            state_q     <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  // an error result never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != rpn_pkg::StatOk) |-> (answer_o == '0))
    else $error("error result with nonzero answer");

  // a sticky error holds until a last token reports it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != rpn_pkg::StatOk && !(state_q == SFin && last_q)) |=>
      (err_q == $past(err_q)))
    else $error("sticky error changed before the result");

  // the stack never grows past its size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q <= NW'(rpn_pkg::StackDepth)))
    else $error("stack depth out of range");

  // a token beat is followed by a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && state_q == SDispatch))
    else $error("token beat not dispatched");

endmodule

`default_nettype wire
